/* sv/tsls_pkg.sv */
// Shared constants and types for the tour swap local search core.
package tsls_pkg;

  // Parameter defaults
  localparam int unsigned MAX_CITIES_DEF = 1024;
  localparam int unsigned COORD_BITS_DEF = 16;

  // Fixed field widths of the request and result channels
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned CRD_W   = 16;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned LEN_W   = 42;
  localparam int unsigned IN_TD_W = 64;
  localparam int unsigned OUT_TD_W = 88;

  localparam logic [CFG_W-1:0] CITY_COUNT_RST = 11'd1024;
  localparam logic [LEN_W-1:0] LENGTH_CAP     = 42'd4397912294400;

  // Request kinds carried in in_tuser
  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD    = 2'd0,
    REQ_MEASURE = 2'd1,
    REQ_SWAP    = 2'd2
  } req_t;

  // Sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_SCAN     = 6'b000010,
    ST_DRAIN    = 6'b000100,
    ST_COMMIT_A = 6'b001000,
    ST_COMMIT_B = 6'b010000,
    ST_DONE     = 6'b100000
  } state_t;

endpackage

/* sv/tsls_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module tsls_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* sv/tour_swap_local_search_core.sv */
// Tour swap local search core: city store, tour cost scan and swap commit.
// Load or refused request: from acceptance through the DONE state to the result register.
// Measure or valid swap: the RAM read port scans the tour one city per cycle, then
// the pipeline drains; a committed swap adds the COMMIT_A and COMMIT_B states.
// One request in flight at a time; a new request is taken while a result waits.
// rst_n (sync, active low) clears control, best cost to zero, city count to 1024.
module tour_swap_local_search_core
  import tsls_pkg::*;
#(
  parameter int unsigned MAX_CITIES = MAX_CITIES_DEF,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // config: city_count
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_W-1:0]    cfg_data,
  // request: tdata = city_index[9:0], coord_x[25:10], coord_y[41:26],
  //          first_index[51:42], second_index[61:52], zero pad [63:62]
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [IN_TD_W-1:0]  in_tdata,
  input  logic [REQ_W-1:0]    in_tuser,   // req_type
  // result: tdata = tour_length[41:0], best_length[83:42], accepted[84], zero pad [87:85]
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OUT_TD_W-1:0] out_tdata,
  output logic                out_tuser   // status
);

  localparam int unsigned AW     = $clog2(MAX_CITIES);
  localparam int unsigned CNT_W  = $clog2(MAX_CITIES + 1);
  localparam int unsigned SQ_W   = 2 * COORD_BITS;
  localparam int unsigned EDGE_W = SQ_W + 1;
  localparam int unsigned ACC_W  = (EDGE_W > LEN_W) ? EDGE_W : LEN_W;

  // Request fields
  logic [REQ_W-1:0] req_type;
  logic [IDX_W-1:0] city_index, first_index, second_index;
  logic [CRD_W-1:0] coord_x, coord_y;

  assign req_type     = in_tuser;
  assign city_index   = in_tdata[9:0];
  assign coord_x      = in_tdata[25:10];
  assign coord_y      = in_tdata[41:26];
  assign first_index  = in_tdata[51:42];
  assign second_index = in_tdata[61:52];

  // Control registers
  state_t            state_r, state_nxt;
  logic [CFG_W-1:0]  city_count_r;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic [CNT_W-1:0]  last_r, last_nxt;
  logic [AW-1:0]     a_r, a_nxt, b_r, b_nxt;
  logic              swap_r, swap_nxt;
  logic [LEN_W-1:0]  best_r, best_nxt;
  logic [LEN_W-1:0]  sum_r, sum_nxt;
  logic [LEN_W-1:0]  res_len_r, res_len_nxt;
  logic              res_acc_r, res_acc_nxt;
  logic              res_st_r, res_st_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_TD_W-1:0] out_data_r;
  logic              out_user_r;

  // Pipeline valids and flags
  logic rd_v_r, rd_first_r, rd_hit_a_r, rd_hit_b_r;
  logic d_v_r, sq_v_r, e_v_r;

  // Datapath registers
  logic [SQ_W-1:0]       prev_r;
  logic [COORD_BITS-1:0] dx_r, dy_r;
  logic [SQ_W-1:0]       sq_x_r, sq_y_r;
  logic [EDGE_W-1:0]     edge_r;
  logic [SQ_W-1:0]       wa_data_r, wb_data_r;

  // RAM ports
  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [SQ_W-1:0] ram_wdata, ram_rdata;

  logic in_acc, done_go, pipe_busy, issue, hit_a, hit_b;
  logic load_bad, swap_bad;
  logic [CNT_W-1:0] n_cur, n_last;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // Effective tour length and index checks
  assign n_cur    = (32'(city_count_r) > MAX_CITIES) ? CNT_W'(MAX_CITIES)
                                                     : CNT_W'(city_count_r);
  assign n_last   = (n_cur < CNT_W'(2)) ? CNT_W'(1) : n_cur;
  assign load_bad = (32'(city_index) >= MAX_CITIES);
  assign swap_bad = (first_index == '0) || (second_index == '0) ||
                    (32'(first_index) >= 32'(n_cur)) ||
                    (32'(second_index) >= 32'(n_cur)) ||
                    (first_index == second_index);

  assign pipe_busy = rd_v_r || d_v_r || sq_v_r || e_v_r;
  assign done_go   = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  // Scan read address: city 0, the swapped tour order, then city 0 again
  assign issue = (state_r == ST_SCAN);
  assign hit_a = swap_r && (k_r == CNT_W'(a_r));
  assign hit_b = swap_r && (k_r == CNT_W'(b_r));

  always_comb begin
    if ((k_r == '0) || (k_r == last_r)) begin
      ram_raddr = '0;
    end else if (hit_a) begin
      ram_raddr = b_r;
    end else if (hit_b) begin
      ram_raddr = a_r;
    end else begin
      ram_raddr = k_r[AW-1:0];
    end
  end

  // Write port: loads from the request side, swap commit writes
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(city_index);
    ram_wdata = {COORD_BITS'(coord_y), COORD_BITS'(coord_x)};
    if (state_r == ST_COMMIT_A) begin
      ram_we    = 1'b1;
      ram_waddr = a_r;
      ram_wdata = wa_data_r;
    end else if (state_r == ST_COMMIT_B) begin
      ram_we    = 1'b1;
      ram_waddr = b_r;
      ram_wdata = wb_data_r;
    end else if (in_acc && (req_type == REQ_LOAD) && !load_bad) begin
      ram_we = 1'b1;
    end
  end

  tsls_ram #(
    .WIDTH (SQ_W),
    .DEPTH (MAX_CITIES)
  ) u_city_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Saturating accumulation of the edge costs
  logic [ACC_W-1:0] acc_sum, acc_room;
  always_comb begin
    acc_sum  = ACC_W'(sum_r) + ACC_W'(edge_r);
    acc_room = ACC_W'(LENGTH_CAP - sum_r);
  end

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    k_nxt       = k_r;
    last_nxt    = last_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    swap_nxt    = swap_r;
    best_nxt    = best_r;
    res_len_nxt = res_len_r;
    res_acc_nxt = res_acc_r;
    res_st_nxt  = res_st_r;
    sum_nxt     = sum_r;
    if (e_v_r) begin
      sum_nxt = (ACC_W'(edge_r) >= acc_room) ? LENGTH_CAP : acc_sum[LEN_W-1:0];
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_len_nxt = '0;
          res_acc_nxt = 1'b0;
          res_st_nxt  = 1'b0;
          k_nxt       = '0;
          last_nxt    = n_last;
          sum_nxt     = '0;
          unique case (req_type)
            REQ_LOAD: begin
              res_st_nxt = load_bad;
              state_nxt  = ST_DONE;
            end
            REQ_MEASURE: begin
              a_nxt     = '0;
              b_nxt     = '0;
              swap_nxt  = 1'b0;
              state_nxt = ST_SCAN;
            end
            REQ_SWAP: begin
              if (swap_bad) begin
                res_st_nxt = 1'b1;
                state_nxt  = ST_DONE;
              end else begin
                a_nxt     = AW'(first_index);
                b_nxt     = AW'(second_index);
                swap_nxt  = 1'b1;
                state_nxt = ST_SCAN;
              end
            end
            default: begin
              res_st_nxt = 1'b1;
              state_nxt  = ST_DONE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        k_nxt = k_r + CNT_W'(1);
        if (k_r == last_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          res_len_nxt = sum_r;
          res_acc_nxt = 1'b0;
          state_nxt   = ST_DONE;
          if (!swap_r) begin
            best_nxt = sum_r;
          end else if (sum_r < best_r) begin
            best_nxt    = sum_r;
            res_acc_nxt = 1'b1;
            state_nxt   = ST_COMMIT_A;
          end
        end
      end
      ST_COMMIT_A: state_nxt = ST_COMMIT_B;
      ST_COMMIT_B: state_nxt = ST_DONE;
      ST_DONE: begin
        if (done_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (done_go) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      city_count_r <= CITY_COUNT_RST;
      best_r       <= '0;
      out_valid_r  <= 1'b0;
      rd_v_r       <= 1'b0;
      d_v_r        <= 1'b0;
      sq_v_r       <= 1'b0;
      e_v_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      best_r      <= best_nxt;
      out_valid_r <= out_valid_nxt;
      rd_v_r      <= issue;
      d_v_r       <= rd_v_r && !rd_first_r;
      sq_v_r      <= d_v_r;
      e_v_r       <= sq_v_r;
      if (cfg_valid && cfg_ready) begin
        city_count_r <= cfg_data;
      end
    end
  end

  // Payload and datapath registers
  logic [COORD_BITS-1:0] cur_x, cur_y, prv_x, prv_y;
  assign cur_x = ram_rdata[COORD_BITS-1:0];
  assign cur_y = ram_rdata[SQ_W-1:COORD_BITS];
  assign prv_x = prev_r[COORD_BITS-1:0];
  assign prv_y = prev_r[SQ_W-1:COORD_BITS];

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    last_r     <= last_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    swap_r     <= swap_nxt;
    sum_r      <= sum_nxt;
    res_len_r  <= res_len_nxt;
    res_acc_r  <= res_acc_nxt;
    res_st_r   <= res_st_nxt;
    rd_first_r <= (k_r == '0);
    rd_hit_a_r <= hit_a;
    rd_hit_b_r <= hit_b;
    // stage 1: absolute coordinate differences, keep swap coordinates
    if (rd_v_r) begin
      prev_r <= ram_rdata;
      dx_r   <= (cur_x > prv_x) ? (cur_x - prv_x) : (prv_x - cur_x);
      dy_r   <= (cur_y > prv_y) ? (cur_y - prv_y) : (prv_y - cur_y);
      if (rd_hit_a_r) begin
        wa_data_r <= ram_rdata;
      end
      if (rd_hit_b_r) begin
        wb_data_r <= ram_rdata;
      end
    end
    // stage 2: squares
    sq_x_r <= SQ_W'(dx_r * dx_r);
    sq_y_r <= SQ_W'(dy_r * dy_r);
    // stage 3: edge cost
    edge_r <= EDGE_W'(sq_x_r) + EDGE_W'(sq_y_r);
    // result register
    if (done_go) begin
      out_data_r <= {3'b000, res_acc_r, best_r, res_len_r};
      out_user_r <= res_st_r;
    end
  end

  // Checks
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN || state_r == ST_DRAIN) |-> !ram_we)
    else $error("city RAM written during a cost scan");

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !(rd_v_r || d_v_r || sq_v_r || e_v_r))
    else $error("scan pipeline busy while idle");

  a_commit_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMMIT_A) |=> (state_r == ST_COMMIT_B))
    else $error("swap commit not completed on both positions");

  a_commit_best: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMMIT_A) |-> (res_acc_r && !res_st_r && best_r == res_len_r))
    else $error("committed swap does not match best cost");

endmodule

/* sim/tour_cost_checker.sv */
// Result checker for the tour swap local search core: tour model, expected results, compare.
module tour_cost_checker
  import tsls_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [IN_TD_W-1:0]  in_tdata,    // city_index, coord_x, coord_y, first_index,
                                           // second_index, pad
  input  logic [REQ_W-1:0]    in_tuser,    // req_type
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [OUT_TD_W-1:0] out_tdata,   // tour_length, best_length, accepted, pad
  input  logic                out_tuser,   // status
  output int unsigned         mismatches,
  output int unsigned         results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic STAT_OK  = 1'b0;
  localparam logic STAT_ERR = 1'b1;
  localparam longint unsigned COST_CAP = 64'(LENGTH_CAP);
  localparam int unsigned REPORT_MAX = 10;

  // Request data word, lowest field last
  typedef struct packed {
    logic [1:0]       pad;
    logic [IDX_W-1:0] second;
    logic [IDX_W-1:0] first;
    logic [CRD_W-1:0] y;
    logic [CRD_W-1:0] x;
    logic [IDX_W-1:0] city;
  } req_word_t;

  // Result data word
  typedef struct packed {
    logic [2:0]       pad;
    logic             swapped;
    logic [LEN_W-1:0] best;
    logic [LEN_W-1:0] tour;
  } res_word_t;

  typedef struct packed {
    logic [LEN_W-1:0] tour;
    logic [LEN_W-1:0] best;
    logic             swapped;
    logic             status;
  } verdict_t;

  // Shadow copy of the block's state
  logic [CRD_W-1:0] city_x [MAX_CITIES_DEF];
  logic [CRD_W-1:0] city_y [MAX_CITIES_DEF];
  logic [LEN_W-1:0] best_cost;
  logic [CFG_W-1:0] city_count;

  verdict_t    due_q[$];
  int unsigned errs;

  function automatic longint unsigned capped_add(input longint unsigned a,
                                                 input longint unsigned b);
    if (a >= COST_CAP || b >= COST_CAP - a) begin
      return COST_CAP;
    end
    return a + b;
  endfunction

  // Squared distance between two stored cities
  function automatic longint unsigned leg_cost(input int unsigned p, input int unsigned q);
    longint unsigned x1, y1, x2, y2, dx, dy;
    x1 = 64'(city_x[p[IDX_W-1:0]]);
    y1 = 64'(city_y[p[IDX_W-1:0]]);
    x2 = 64'(city_x[q[IDX_W-1:0]]);
    y2 = 64'(city_y[q[IDX_W-1:0]]);
    dx = (x1 > x2) ? x1 - x2 : x2 - x1;
    dy = (y1 > y2) ? y1 - y2 : y2 - y1;
    return dx * dx + dy * dy;
  endfunction

  // Closed tour cost with positions a and b exchanged (a == b: plain tour)
  function automatic longint unsigned tour_sum(input int unsigned n, input int unsigned a,
                                               input int unsigned b);
    longint unsigned acc;
    int unsigned     prev, c, i;
    acc  = 0;
    prev = 0;
    for (i = 1; i < n; i++) begin
      c    = (i == a) ? b : ((i == b) ? a : i);
      acc  = capped_add(acc, leg_cost(prev, c));
      prev = c;
    end
    return capped_add(acc, leg_cost(prev, 0));
  endfunction

  // Applies one request to the shadow state and returns what the block must answer
  function automatic verdict_t apply_request(input logic [REQ_W-1:0] kind,
                                             input req_word_t rq);
    verdict_t        v;
    int unsigned     n, a, b;
    longint unsigned len;
    logic [CRD_W-1:0] tx, ty;
    n = (32'(city_count) > MAX_CITIES_DEF) ? MAX_CITIES_DEF : 32'(city_count);
    v = '0;
    v.status = STAT_OK;
    case (kind)
      REQ_LOAD: begin
        city_x[rq.city] = rq.x;
        city_y[rq.city] = rq.y;
      end
      REQ_MEASURE: begin
        len       = tour_sum(n, 0, 0);
        best_cost = len[LEN_W-1:0];
        v.tour    = len[LEN_W-1:0];
      end
      REQ_SWAP: begin
        a = 32'(rq.first);
        b = 32'(rq.second);
        if (a == 0 || b == 0 || a >= n || b >= n || a == b) begin
          v.status = STAT_ERR;
        end else begin
          len    = tour_sum(n, a, b);
          v.tour = len[LEN_W-1:0];
          if (len < 64'(best_cost)) begin
            tx                = city_x[rq.first];
            ty                = city_y[rq.first];
            city_x[rq.first]  = city_x[rq.second];
            city_y[rq.first]  = city_y[rq.second];
            city_x[rq.second] = tx;
            city_y[rq.second] = ty;
            best_cost = len[LEN_W-1:0];
            v.swapped = 1'b1;
          end
        end
      end
      default: begin
        v.status = STAT_ERR;
      end
    endcase
    v.best = best_cost;
    return v;
  endfunction

  // Compare results first, then take config and new requests of the same edge
  always @(posedge clk) begin
    verdict_t  want, got;
    res_word_t rw;
    if (!rst_n) begin
      best_cost  = '0;
      city_count = CITY_COUNT_RST;
      due_q.delete();
      errs = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        rw          = res_word_t'(out_tdata);
        got.tour    = rw.tour;
        got.best    = rw.best;
        got.swapped = rw.swapped;
        got.status  = out_tuser;
        if (due_q.size() == 0) begin
          errs++;
          if (errs <= REPORT_MAX) begin
            $display("[%0t] result with none outstanding: tour %0d best %0d acc %0b st %0b",
                     $time, got.tour, got.best, got.swapped, got.status);
          end
        end else begin
          want = due_q.pop_front();
          if (got.tour !== want.tour || got.best !== want.best ||
              got.swapped !== want.swapped || got.status !== want.status) begin
            errs++;
            if (errs <= REPORT_MAX) begin
              $display("[%0t] mismatch (exp/act): tour %0d/%0d best %0d/%0d acc %0b/%0b st %0b/%0b",
                       $time, want.tour, got.tour, want.best, got.best,
                       want.swapped, got.swapped, want.status, got.status);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        city_count = cfg_data;
      end
      if (in_tvalid && in_tready) begin
        due_q.push_back(apply_request(in_tuser, req_word_t'(in_tdata)));
      end
    end
    mismatches  <= errs;
    results_due <= due_q.size();
  end

endmodule

/* sim/tb_tour_swap_local_search_core.sv */
// Testbench top for the tour swap local search core: clock, reset, requests and verdict.
module tb_tour_swap_local_search_core;
  timeunit 1ns;
  timeprecision 1ps;
  import tsls_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned HOLD_CYCLES    = 600;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned TAIL_CYCLES    = 40;
  localparam int unsigned NUM_PHASES     = 4;
  localparam int unsigned PHASE_REPS     = 8;
  // at least 512 longest edges are needed to reach the cost ceiling
  localparam int unsigned FILL_CITIES    = 516;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_data   = '0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [IN_TD_W-1:0]  in_tdata   = '0;  // city_index, coord_x, coord_y, first_index,
                                         // second_index, zero pad
  logic [REQ_W-1:0]    in_tuser   = '0;  // req_type
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_TD_W-1:0] out_tdata;        // tour_length, best_length, accepted, zero pad
  logic                out_tuser;        // status

  int unsigned mismatches, results_due;
  int unsigned quiet_cycles = 0;
  bit          calm = 1'b0;
  bit          long_hold_req = 1'b0;

  always #6 clk = ~clk;

  tour_swap_local_search_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  tour_cost_checker i_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  // Watchdog: cycles with no request moving on any channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", quiet_cycles);
        $display("** tour_swap_local_search_core: FAILED **");
        $finish;
      end
    end
  end

  // Result side back-pressure: random stalls, one long hold-off on request
  initial begin
    int unsigned stall_left;
    bit          hold_taken;
    stall_left = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (long_hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        stall_left = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic logic [IN_TD_W-1:0] pack_req(input logic [IDX_W-1:0] city,
                                                  input logic [CRD_W-1:0] x,
                                                  input logic [CRD_W-1:0] y,
                                                  input logic [IDX_W-1:0] first,
                                                  input logic [IDX_W-1:0] second);
    return {2'b00, second, first, y, x, city};
  endfunction

  // Random filler for fields a request kind ignores
  function automatic logic [IDX_W-1:0] rnd_idx();
    return IDX_W'($urandom);
  endfunction

  function automatic logic [CRD_W-1:0] rnd_crd();
    return CRD_W'($urandom);
  endfunction

  function automatic logic [CRD_W-1:0] any_coord();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return rnd_crd();
    endcase
  endfunction

  // Offer one request, optionally after an idle burst, and wait for acceptance
  task automatic push_req(input logic [REQ_W-1:0] kind, input logic [IN_TD_W-1:0] data);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic load_city(input logic [IDX_W-1:0] idx, input logic [CRD_W-1:0] x,
                           input logic [CRD_W-1:0] y);
    push_req(REQ_LOAD, pack_req(idx, x, y, rnd_idx(), rnd_idx()));
  endtask

  task automatic measure_tour();
    push_req(REQ_MEASURE, pack_req(rnd_idx(), rnd_crd(), rnd_crd(), rnd_idx(), rnd_idx()));
  endtask

  task automatic propose_swap(input logic [IDX_W-1:0] a, input logic [IDX_W-1:0] b);
    push_req(REQ_SWAP, pack_req(rnd_idx(), rnd_crd(), rnd_crd(), a, b));
  endtask

  // Stop offering and wait until every outstanding result has come back
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  task automatic write_count(input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One random request; swaps are most common, mostly legal ones inside the current tour
  task automatic random_item(input int unsigned n);
    int unsigned pick, a, b;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      if (n == 0 || $urandom_range(0, 3) == 0) begin
        a = $urandom_range(0, MAX_CITIES_DEF - 1);
      end else begin
        a = $urandom_range(0, n - 1);
      end
      load_city(IDX_W'(a), any_coord(), any_coord());
    end else if (pick < 42) begin
      measure_tour();
    end else if (pick < 94) begin
      a = $urandom_range(0, MAX_CITIES_DEF - 1);
      b = $urandom_range(0, MAX_CITIES_DEF - 1);
      if (n >= 3 && $urandom_range(0, 4) != 0) begin
        a = $urandom_range(1, n - 1);
        b = $urandom_range(1, n - 2);
        if (b >= a) begin
          b++;
        end
      end else begin
        case ($urandom_range(0, 3))
          0: a = 0;
          1: b = a;
          2: if (n < MAX_CITIES_DEF) a = $urandom_range(n, MAX_CITIES_DEF - 1);
          default: ;
        endcase
      end
      propose_swap(IDX_W'(a), IDX_W'(b));
    end else begin
      push_req(REQ_UNUSED, pack_req(rnd_idx(), rnd_crd(), rnd_crd(), rnd_idx(), rnd_idx()));
    end
  endtask

  initial begin
    int unsigned phase_n[NUM_PHASES];
    int unsigned n, reps, i, p;
    phase_n = '{3, 12, 40, 7};

    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Four-city tour with corner and inner coordinates, swap before any measure
    write_count(4);
    load_city(0, 16'h0000, 16'h0000);
    load_city(1, 16'hFFFF, 16'hFFFF);
    load_city(2, 16'hAAAA, 16'h5555);
    load_city(3, 16'h5555, 16'hAAAA);
    propose_swap(1, 2);
    measure_tour();
    propose_swap(1, 3);
    propose_swap(2, 3);
    // bad positions: start city, equal, past the tour, top of range
    propose_swap(0, 2);
    propose_swap(2, 2);
    propose_swap(1, 4);
    propose_swap(1023, 1);
    propose_swap(3, 0);
    push_req(REQ_UNUSED, pack_req(rnd_idx(), rnd_crd(), rnd_crd(), rnd_idx(), rnd_idx()));
    load_city(1023, 16'hFFFF, 16'h0000);
    measure_tour();

    // Smallest tours: every swap is refused
    settle();
    write_count(2);
    measure_tour();
    propose_swap(1, 1);
    propose_swap(1, 2);
    settle();
    write_count(1);
    measure_tour();
    propose_swap(1, 2);
    settle();
    write_count(0);
    measure_tour();
    propose_swap(2, 1);

    // Fill the start of the store with alternating corners: the tour saturates
    settle();
    write_count(CFG_W'(FILL_CITIES));
    for (i = 0; i < FILL_CITIES; i++) begin
      load_city(IDX_W'(i), i[0] ? 16'hFFFF : 16'h0000, i[0] ? 16'hFFFF : 16'h0000);
    end
    measure_tour();
    propose_swap(1, 2);
    propose_swap(IDX_W'(FILL_CITIES - 1), IDX_W'(FILL_CITIES / 2));

    // Random phases over several tour sizes
    for (p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_count(CFG_W'(phase_n[p]));
      n    = (phase_n[p] > MAX_CITIES_DEF) ? MAX_CITIES_DEF : phase_n[p];
      reps = PHASE_REPS;
      if (p == NUM_PHASES - 1) begin
        calm = 1'b1;
      end
      measure_tour();
      for (i = 0; i < reps; i++) begin
        if (p == 1 && i == 2) begin
          long_hold_req = 1'b1;
        end
        random_item(n);
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && results_due == 0) begin
      $display("** tour_swap_local_search_core: PASSED **");
    end else begin
      $display("** tour_swap_local_search_core: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/tsls_pkg.sv
sv/tsls_ram.sv
sv/tour_swap_local_search_core.sv
sim/tour_cost_checker.sv
sim/tb_tour_swap_local_search_core.sv
